// ===== rtl/bloom_filter_insert_query_defines.svh =====
// assertion macros used by the checker file
`ifndef BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define BFIQ_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BFIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfiq_pkg.sv =====
package bfiq_pkg;

  // default sizes of the filter
  localparam int MAX_BITS_DEF   = 16384;
  localparam int MAX_PROBES_DEF = 8;

  // register reset values, also used when a register holds zero
  localparam int DEFAULT_BITS   = 10000;
  localparam int DEFAULT_PROBES = 3;

  // register and port widths
  localparam int FBITS_W   = 15;
  localparam int PCOUNT_W  = 4;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;
  localparam int BYTE_W    = 8;
  localparam int TDATA_W   = 8;

  // hash: 64-bit wrapping, multiplier 31 done as (x << 5) - x
  localparam int HASH_W     = 64;
  localparam int HASH_SHIFT = 5;

  // store rows of eight bits
  localparam int ROW_BITS  = 8;
  localparam int ROW_SEL_W = 3;

  // modulo unit retires four dividend bits per cycle
  localparam int STEP_BITS = 4;
  localparam int MOD_STEPS = HASH_W / STEP_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 1'b1;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  // store port commands
  typedef struct packed {
    logic rd;
    logic wr;
  } store_cmd_t;

endpackage

// ===== rtl/bloom_filter_insert_query.sv =====
// channel  dir  tdata                 tuser                          tlast
// s        in   key_byte [7:0]        action [0], byte_valid [1]     last
// m        out  might_contain [0]     done_action                    -
// cfg      in   plain write: cfg_we, cfg_index, cfg_data
//
// a key byte that is not the last is absorbed in the idle state, which stays ready for the next byte
// a key end runs, per probe, a start state, the shared modulo unit (four bits a cycle),
//   a store read and, for an insert, a store write-back; then a done state
// after reset the store is cleared one row a cycle, (MAX_BITS+7)/8 rows
//   (2048 at the default size), with s_tready low
// a finished result sits in the output register; a new key's result waits in
//   the done state until that word has been taken
module bloom_filter_insert_query #(
  parameter int MAX_BITS   = bfiq_pkg::MAX_BITS_DEF,
  parameter int MAX_PROBES = bfiq_pkg::MAX_PROBES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfiq_pkg::BYTE_W-1:0]   s_tdata,   // key_byte
  input  logic [1:0]                    s_tuser,   // action, byte_valid
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bfiq_pkg::TDATA_W-1:0]  m_tdata,   // might_contain, zero pad
  output logic                          m_tuser,   // done_action
  input  logic                          cfg_we,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfiq_pkg::CFG_W-1:0]    cfg_data
);
  import bfiq_pkg::*;

  localparam int NW   = $clog2(MAX_BITS + 1);
  localparam int IW   = ($clog2(MAX_BITS) > ROW_SEL_W) ? $clog2(MAX_BITS) : ROW_SEL_W + 1;
  localparam int RAW  = IW - ROW_SEL_W;
  localparam int ROWS = (MAX_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int PW   = $clog2(MAX_PROBES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_READ,
    S_DONE
  } state_t;

  state_t              state;
  logic [FBITS_W-1:0]  filter_bits;
  logic [PCOUNT_W-1:0] probe_count;
  logic [HASH_W-1:0]   poly;
  logic [HASH_W-1:0]   lpow;
  logic [HASH_W-1:0]   vcur;
  logic [HASH_W-1:0]   poly_next;
  logic [HASH_W-1:0]   lpow_next;
  action_t             action;
  logic                all_set;
  logic [PW-1:0]       probe_idx;
  logic [ROW_SEL_W-1:0] bit_sel;
  logic [RAW-1:0]      row_addr;
  logic                m_res;

  logic [NW-1:0]       n_eff;
  logic [PW-1:0]       p_eff;
  logic [31:0]         fb_sel;
  logic [31:0]         pc_sel;

  logic                mod_start;
  logic                mod_done;
  logic [NW-1:0]       mod_rem;

  store_cmd_t          st_cmd;
  logic [RAW-1:0]      st_addr;
  logic [ROW_BITS-1:0] st_wdata;
  logic [ROW_BITS-1:0] st_rdata;
  logic                st_ready;

  // sizes in use, zero meaning the default, saturated at the maximum
  always_comb begin
    fb_sel = (filter_bits == '0) ? 32'(DEFAULT_BITS) : 32'(filter_bits);
    n_eff  = (fb_sel > 32'(MAX_BITS)) ? NW'(MAX_BITS) : NW'(fb_sel);
    pc_sel = (probe_count == '0) ? 32'(DEFAULT_PROBES) : 32'(probe_count);
    p_eff  = (pc_sel > 32'(MAX_PROBES)) ? PW'(MAX_PROBES) : PW'(pc_sel);
  end

  // hash absorb, times 31 as shift and subtract
  always_comb begin
    if (s_tuser[1]) begin
      poly_next = (poly << HASH_SHIFT) - poly + HASH_W'(s_tdata);
      lpow_next = (lpow << HASH_SHIFT) - lpow;
    end else begin
      poly_next = poly;
      lpow_next = lpow;
    end
  end

  assign s_tready  = (state == S_IDLE) && st_ready;
  assign mod_start = (state == S_START);

  // store access: read at the probe row, write back for an insert
  always_comb begin
    st_cmd.rd = (state == S_WAIT) && mod_done;
    st_cmd.wr = (state == S_READ) && (action == ACT_INSERT);
    st_addr   = (state == S_WAIT) ? mod_rem[IW-1:ROW_SEL_W] : row_addr;
    st_wdata  = st_rdata | (ROW_BITS'(1) << bit_sel);
  end

  assign m_tdata = {(TDATA_W - 1)'(0), m_res};

  // sequencer, hash state, config registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      filter_bits <= FBITS_W'(DEFAULT_BITS);
      probe_count <= PCOUNT_W'(DEFAULT_PROBES);
      poly        <= '0;
      lpow        <= HASH_W'(1);
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER_BITS: filter_bits <= cfg_data[FBITS_W-1:0];
          REG_PROBE_COUNT: probe_count <= cfg_data[PCOUNT_W-1:0];
          default: ;
        endcase
      end
      // result word taken, the done state reloads it on its own
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (s_tlast) begin
              poly      <= '0;
              lpow      <= lpow_next;
              vcur      <= poly_next;
              action    <= action_t'(s_tuser[0]);
              probe_idx <= '0;
              all_set   <= 1'b1;
              state     <= S_START;
            end else begin
              poly <= poly_next;
              lpow <= lpow_next;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mod_done) begin
            row_addr <= mod_rem[IW-1:ROW_SEL_W];
            bit_sel  <= mod_rem[ROW_SEL_W-1:0];
            state    <= S_READ;
          end
        end
        S_READ: begin
          if ((action == ACT_QUERY) && !st_rdata[bit_sel]) begin
            all_set <= 1'b0;
          end
          vcur <= vcur + lpow;
          if (PW'(probe_idx + 1'b1) == p_eff) begin
            state <= S_DONE;
          end else begin
            probe_idx <= probe_idx + 1'b1;
            state     <= S_START;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_res    <= (action == ACT_INSERT) || all_set;
            m_tuser  <= action;
            lpow     <= HASH_W'(1);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bfiq_mod #(
    .REM_W (NW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (vcur),
    .modulus  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  bfiq_store #(
    .ROWS   (ROWS),
    .ROW_AW (RAW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (st_cmd),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata),
    .ready (st_ready)
  );

endmodule

// ===== rtl/bfiq_mod.sv =====
module bfiq_mod #(
  parameter int REM_W = $clog2(bfiq_pkg::MAX_BITS_DEF + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bfiq_pkg::HASH_W-1:0] dividend,
  input  logic [REM_W-1:0]          modulus,
  output logic                      done,
  output logic [REM_W-1:0]          rem
);
  import bfiq_pkg::*;

  logic [HASH_W-1:0]    num;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;
  logic [REM_W-1:0]     rem_next;

  // restoring remainder, several dividend bits per cycle from the top
  always_comb begin
    logic [REM_W:0] t;
    rem_next = rem;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {rem_next, num[HASH_W-1-j]};
      if (t >= {1'b0, modulus}) begin
        t = t - {1'b0, modulus};
      end
      rem_next = t[REM_W-1:0];
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        num  <= dividend;
        rem  <= '0;
        cnt  <= MOD_CNT_W'(MOD_STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        num <= num << STEP_BITS;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/bfiq_store.sv =====
module bfiq_store #(
  parameter int ROWS   = (bfiq_pkg::MAX_BITS_DEF + bfiq_pkg::ROW_BITS - 1) / bfiq_pkg::ROW_BITS,
  parameter int ROW_AW = $clog2(bfiq_pkg::MAX_BITS_DEF) - bfiq_pkg::ROW_SEL_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfiq_pkg::store_cmd_t          cmd,
  input  logic [ROW_AW-1:0]             addr,
  input  logic [bfiq_pkg::ROW_BITS-1:0] wdata,
  output logic [bfiq_pkg::ROW_BITS-1:0] rdata,
  output logic                          ready
);
  import bfiq_pkg::*;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic                clr_busy;
  logic [ROW_AW-1:0]   clr_addr;

  assign ready = !clr_busy;

  // clearing pass after reset, one row a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == ROW_AW'(ROWS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // single port row memory, registered read
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/bfiq_checker.sv =====
`include "bloom_filter_insert_query_defines.svh"

module bfiq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bfiq_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tuser
);
  import bfiq_pkg::*;

  // stalled result word stays offered
  `BFIQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")

  // stalled result word keeps its payload
  `BFIQ_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

  // an insert always reports a hit
  `BFIQ_ASSERT(a_insert_hit, m_tvalid && (m_tuser == ACT_INSERT), m_tdata[0], "insert result not set")

  // store clearing keeps input closed right after reset
  `BFIQ_ASSERT(a_clear_closed, $past(rst), !s_tready, "input open during store clear")

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);

// ===== test/tb_bloom_filter_insert_query.sv =====
module tb_bloom_filter_insert_query;
  timeunit 1ns;
  timeprecision 1ps;
  import bfiq_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int MAX_KEY_LEN    = 8;
  localparam int PHASE_ITEMS    = 185;
  localparam int NUM_PHASES     = 10;
  localparam int MODEL_AW       = $clog2(MAX_BITS_DEF);

  // one input word as the driver presents it
  typedef struct packed {
    action_t           act;
    logic              bval;
    logic              lst;
    logic [BYTE_W-1:0] kbyte;
  } key_word_t;

  // one predicted result word
  typedef struct packed {
    action_t act;
    logic    hit;
  } verdict_t;

  typedef struct {
    logic [8*MAX_KEY_LEN-1:0] bytes;
    int                       len;
  } key_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic [1:0]           s_tuser   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tuser;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // pending input words and results still owed by the block
  key_word_t word_q[$];
  verdict_t  verdict_q[$];
  key_t      known_keys[$];
  key_word_t next_word;
  verdict_t  want;

  // shadow of the filter, the hash state and the registers
  bit                  filter_model [MAX_BITS_DEF];
  logic [HASH_W-1:0]   hash_acc   = 64'd0;
  logic [HASH_W-1:0]   len_pow    = 64'd1;
  logic [FBITS_W-1:0]  bits_reg   = FBITS_W'(DEFAULT_BITS);
  logic [PCOUNT_W-1:0] probes_reg = PCOUNT_W'(DEFAULT_PROBES);

  int mismatches     = 0;
  int items_sent     = 0;
  int words_pushed   = 0;
  int words_accepted = 0;
  int stall_cycles   = 0;
  bit no_idle        = 1'b0;

  bloom_filter_insert_query DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // absorb one accepted word; on a key end probe the filter shadow
  function automatic void predict_word(input key_word_t w);
    logic [HASH_W-1:0] nbits, nprobes, idx, i;
    logic              all_set;
    if (w.bval) begin
      hash_acc = hash_acc * 64'd31 + 64'(w.kbyte);
      len_pow  = len_pow * 64'd31;
    end
    if (w.lst) begin
      nbits = (bits_reg == 0) ? 64'(DEFAULT_BITS) : 64'(bits_reg);
      if (nbits > 64'(MAX_BITS_DEF)) nbits = 64'(MAX_BITS_DEF);
      nprobes = (probes_reg == 0) ? 64'(DEFAULT_PROBES) : 64'(probes_reg);
      if (nprobes > 64'(MAX_PROBES_DEF)) nprobes = 64'(MAX_PROBES_DEF);
      all_set = 1'b1;
      for (i = '0; i < nprobes; i++) begin
        idx = (hash_acc + i * len_pow) % nbits;
        if (w.act == ACT_INSERT) filter_model[idx[MODEL_AW-1:0]] = 1'b1;
        else if (!filter_model[idx[MODEL_AW-1:0]]) all_set = 1'b0;
      end
      hash_acc = 64'd0;
      len_pow  = 64'd1;
      verdict_q.push_back('{act: w.act, hit: (w.act == ACT_INSERT) || all_set});
    end
  endfunction

  function automatic void push_word(input action_t act, input logic [BYTE_W-1:0] b,
                                    input logic bval, input logic lst);
    word_q.push_back('{act: act, bval: bval, lst: lst, kbyte: b});
    words_pushed++;
    items_sent++;
  endfunction

  // action on non-final words is random, the block only looks at the last one
  function automatic void push_key(input key_t k, input action_t act,
                                   input bit tail_invalid, input int noise_pct);
    int  n;
    bit  fin;
    for (n = 0; n < k.len; n++) begin
      fin = (n == k.len - 1) && !tail_invalid;
      if (int'($urandom_range(99)) < noise_pct)
        push_word(action_t'($urandom_range(1)), BYTE_W'($urandom), 1'b0, 1'b0);
      push_word(fin ? act : action_t'($urandom_range(1)), k.bytes[8*n +: 8], 1'b1, fin);
    end
    if (k.len == 0 || tail_invalid) push_word(act, BYTE_W'($urandom), 1'b0, 1'b1);
  endfunction

  // mostly short keys, now and then empty or full length
  function automatic key_t random_key();
    key_t k;
    k.bytes = {$urandom, $urandom};
    k.len   = ($urandom_range(3) == 0) ? int'($urandom_range(MAX_KEY_LEN))
                                       : int'($urandom_range(1, 3));
    return k;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FILTER_BITS) bits_reg = val[FBITS_W-1:0];
    else probes_reg = val[PCOUNT_W-1:0];
  endtask

  // unused upper bits of the probe count write carry random junk
  task automatic set_config(input int fbits, input int pcount);
    logic [CFG_W-1:0] v;
    v = CFG_W'($urandom);
    v[PCOUNT_W-1:0] = PCOUNT_W'(pcount);
    write_reg(REG_FILTER_BITS, CFG_W'(fbits));
    write_reg(REG_PROBE_COUNT, v);
  endtask

  // wait until every word is taken and every result is back, then let
  // the block idle before the next test step
  task automatic settle();
    do @(posedge clk);
    while (words_accepted != words_pushed || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (word_q.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
        next_word = word_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_word.kbyte;
        s_tuser  <= {next_word.bval, next_word.act};
        s_tlast  <= next_word.lst;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      words_accepted++;
      predict_word('{act: action_t'(s_tuser[0]), bval: s_tuser[1], lst: s_tlast,
                     kbyte: s_tdata});
    end
  end

  // result side: random backpressure and compare against oldest prediction
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 30);
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: done_action %0d might_contain %0d",
                   m_tuser, m_tdata[0]);
      end else begin
        want = verdict_q.pop_front();
        if (m_tuser !== want.act || m_tdata !== TDATA_W'(want.hit)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: done_action exp %0d got %0d, tdata exp %h got %h",
                     want.act, m_tuser, TDATA_W'(want.hit), m_tdata);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int   phase_bits   [NUM_PHASES] = '{16384, 1, 0, 32767, 50, -1, 16385, 10000, 200, -1};
    int   phase_probes [NUM_PHASES] = '{8, 1, 0, 15, 2, -1, 9, 3, 5, -1};
    key_t k;
    int   p, r, n, j, target, fb, pc;
    bit   tail;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty key misses, then hits once inserted
    push_key('{bytes: '0, len: 0}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: '0, len: 0}, ACT_INSERT, 1'b0, 0);
    push_key('{bytes: '0, len: 0}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: 64'hFF00, len: 2}, ACT_INSERT, 1'b0, 0);
    push_key('{bytes: 64'hFF00, len: 2}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: 64'hFF, len: 1}, ACT_QUERY, 1'b0, 0);
    // invalid byte inside a key absorbs nothing
    push_word(ACT_QUERY, 8'h12, 1'b1, 1'b0);
    push_word(ACT_QUERY, 8'h34, 1'b0, 1'b0);
    push_word(ACT_INSERT, 8'h56, 1'b1, 1'b1);
    // same key closed by an invalid last word
    push_key('{bytes: 64'h5612, len: 2}, ACT_QUERY, 1'b1, 0);
    settle();

    // single bit, single probe
    set_config(1, 1);
    push_key('{bytes: 64'hA5, len: 1}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: 64'h5A, len: 1}, ACT_INSERT, 1'b0, 0);
    settle();

    // zero registers fall back to the defaults
    set_config(0, 0);
    push_key('{bytes: 64'hFF00, len: 2}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: 64'h5612, len: 2}, ACT_QUERY, 1'b0, 0);
    settle();

    // oversize registers saturate
    set_config(32767, 15);
    push_key('{bytes: '1, len: MAX_KEY_LEN}, ACT_INSERT, 1'b0, 0);
    push_key('{bytes: '1, len: MAX_KEY_LEN}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: '0, len: MAX_KEY_LEN}, ACT_QUERY, 1'b0, 0);
    settle();
    set_config(16385, 9);
    push_key('{bytes: '1, len: MAX_KEY_LEN}, ACT_QUERY, 1'b0, 0);
    push_key('{bytes: 64'hFF00, len: 2}, ACT_QUERY, 1'b0, 0);
    settle();

    // random phases, one setting each
    for (p = 0; p < NUM_PHASES; p++) begin
      fb = (phase_bits[p] < 0) ? int'($urandom_range(1, MAX_BITS_DEF)) : phase_bits[p];
      pc = (phase_probes[p] < 0) ? int'($urandom_range(15)) : phase_probes[p];
      set_config(fb, pc);
      no_idle = (p == 3);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        r    = $urandom_range(99);
        tail = ($urandom_range(9) == 0);
        if (r < 10) begin
          // loose words with random flags, closed by a last word
          n = $urandom_range(1, 6);
          for (j = 0; j < n; j++)
            push_word(action_t'($urandom_range(1)), BYTE_W'($urandom), 1'($urandom),
                      (j == n - 1) ? 1'b1 : 1'($urandom_range(3) == 0));
        end else if (r < 45) begin
          k = random_key();
          push_key(k, ACT_INSERT, tail, 8);
          known_keys.push_back(k);
          if (known_keys.size() > 64) void'(known_keys.pop_front());
        end else if (r < 80 && known_keys.size() != 0) begin
          k = known_keys[$urandom_range(known_keys.size() - 1)];
          push_key(k, ACT_QUERY, tail, 8);
        end else begin
          push_key(random_key(), ACT_QUERY, tail, 8);
        end
      end
      settle();
      no_idle = 1'b0;
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bfiq_pkg.sv
rtl/bfiq_mod.sv
rtl/bfiq_store.sv
rtl/bloom_filter_insert_query.sv
rtl/bfiq_checker.sv
test/tb_bloom_filter_insert_query.sv
